// File: rtl/vec3_keyframe_sampler_defines.svh
// Assertion macros shared by the keyframe sampler RTL.
`ifndef VEC3_KEYFRAME_SAMPLER_DEFINES_SVH
`define VEC3_KEYFRAME_SAMPLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define VKFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VKFS_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VKFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define VKFS_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/vkfs_pkg.sv
// Types, constants and codes of the keyframe sampler.
package vkfs_pkg;

  localparam int MAX_KEYS   = 64;
  localparam int FRAC_BITS  = 16;
  localparam int KEY_AW     = $clog2(MAX_KEYS);
  localparam int CNT_W      = KEY_AW + 1;
  localparam int U_W        = FRAC_BITS + 1;
  localparam int H_W        = FRAC_BITS + 4;
  localparam int M_W        = 64 - FRAC_BITS;
  localparam int SPLIT      = M_W / 2;
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 72;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int QDEPTH     = 2;  // power of two
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'd1;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_STEP    = 2'd1,
    MODE_HERMITE = 2'd2,
    MODE_ZERO    = 2'd3
  } interp_mode_e;

  typedef enum logic [1:0] {
    CLS_WRITE,
    CLS_EMPTY,
    CLS_SAMPLE
  } item_cls_e;

  typedef enum logic [3:0] {
    BK_IDLE, BK_FIRST, BK_LAST, BK_SRCH, BK_DIV, BK_MUL, BK_ACC, BK_FIN, BK_OUT
  } back_state_e;

  typedef enum logic [3:0] {
    ST_T2, ST_T3, ST_M0, ST_M1, ST_H00, ST_H01,
    ST_H10L, ST_H10H, ST_H11L, ST_H11H, ST_LIN
  } mac_step_e;

  // one keyframe row; key_time carries the query time for samples
  typedef struct packed {
    logic [31:0]      key_time;
    logic [2:0][31:0] val;
    logic [2:0][31:0] tan_in;
    logic [2:0][31:0] tan_out;
  } key_row_t;

  typedef struct packed {
    item_cls_e  cls;
    logic [5:0] key_index;
    key_row_t   row;
  } q_item_t;

  typedef struct packed {
    interp_mode_e     mode;
    logic [CNT_W-1:0] n_keys;
  } cfg_t;

  // Hermite multiply sequence
  function automatic mac_step_e next_step(mac_step_e s);
    mac_step_e n;
    case (s)
      ST_T2:   n = ST_T3;
      ST_T3:   n = ST_M0;
      ST_M0:   n = ST_M1;
      ST_M1:   n = ST_H00;
      ST_H00:  n = ST_H01;
      ST_H01:  n = ST_H10L;
      ST_H10L: n = ST_H10H;
      ST_H10H: n = ST_H11L;
      ST_H11L: n = ST_H11H;
      default: n = ST_LIN;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/vkfs_front.sv
// Front end: configuration registers, request classification, queue push.
module vkfs_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [vkfs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [vkfs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 operation_i,
  input  logic [5:0]                           key_index_i,
  input  logic [31:0]                          time_value_i,
  input  logic signed [31:0]                   value_x_i,
  input  logic signed [31:0]                   value_y_i,
  input  logic signed [31:0]                   value_z_i,
  input  logic signed [31:0]                   tan_in_x_i,
  input  logic signed [31:0]                   tan_in_y_i,
  input  logic signed [31:0]                   tan_in_z_i,
  input  logic signed [31:0]                   tan_out_x_i,
  input  logic signed [31:0]                   tan_out_y_i,
  input  logic signed [31:0]                   tan_out_z_i,
  input  logic                                 q_full_i,
  output logic                                 in_stall_o,
  output logic                                 q_push_o,
  output vkfs_pkg::q_item_t                    q_item_o,
  output vkfs_pkg::cfg_t                       cfg_o
);

  vkfs_pkg::interp_mode_e mode_q;
  logic [6:0]             count_q;
  logic [vkfs_pkg::CNT_W-1:0] n_keys;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= vkfs_pkg::MODE_LINEAR;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vkfs_pkg::CFG_INTERP: mode_q  <= vkfs_pkg::interp_mode_e'(cfg_data_i[1:0]);
        vkfs_pkg::CFG_COUNT:  count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // clamp key count to table size
  always_comb begin
    if (int'(count_q) > vkfs_pkg::MAX_KEYS) begin
      n_keys = vkfs_pkg::CNT_W'(vkfs_pkg::MAX_KEYS);
    end else begin
      n_keys = vkfs_pkg::CNT_W'(count_q);
    end
  end

  assign cfg_o.mode   = mode_q;
  assign cfg_o.n_keys = n_keys;

  // classify and pack the request
  always_comb begin
    q_item_o.key_index        = key_index_i;
    q_item_o.row.key_time     = time_value_i;
    q_item_o.row.val[0]       = value_x_i;
    q_item_o.row.val[1]       = value_y_i;
    q_item_o.row.val[2]       = value_z_i;
    q_item_o.row.tan_in[0]    = tan_in_x_i;
    q_item_o.row.tan_in[1]    = tan_in_y_i;
    q_item_o.row.tan_in[2]    = tan_in_z_i;
    q_item_o.row.tan_out[0]   = tan_out_x_i;
    q_item_o.row.tan_out[1]   = tan_out_y_i;
    q_item_o.row.tan_out[2]   = tan_out_z_i;
    if (!operation_i) begin
      q_item_o.cls = vkfs_pkg::CLS_WRITE;
    end else if (n_keys == '0) begin
      q_item_o.cls = vkfs_pkg::CLS_EMPTY;
    end else begin
      q_item_o.cls = vkfs_pkg::CLS_SAMPLE;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// File: rtl/vkfs_fifo.sv
// Short request queue between front and back end.
module vkfs_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vkfs_pkg::q_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output vkfs_pkg::q_item_t item_o
);

  localparam int PW = (vkfs_pkg::QDEPTH > 1) ? $clog2(vkfs_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(vkfs_pkg::QDEPTH + 1);

  vkfs_pkg::q_item_t      mem_q [vkfs_pkg::QDEPTH];
  logic [PW-1:0]          wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == CW'(vkfs_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_comb begin
    wr_d  = do_push ? wr_q + PW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: rtl/vkfs_back.sv
// Back end: keyframe table, search, divider, shared multiplier, output register.
`include "vec3_keyframe_sampler_defines.svh"
module vkfs_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vkfs_pkg::cfg_t           cfg_i,
  input  logic                     q_valid_i,
  input  vkfs_pkg::q_item_t        q_item_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [31:0]       result_x_o,
  output logic signed [31:0]       result_y_o,
  output logic signed [31:0]       result_z_o,
  output logic                     table_empty_o
);

  localparam logic signed [vkfs_pkg::ACC_W-1:0] SAT_MAX =
    vkfs_pkg::ACC_W'($signed(32'h7fff_ffff));
  localparam logic signed [vkfs_pkg::ACC_W-1:0] SAT_MIN =
    vkfs_pkg::ACC_W'($signed(32'h8000_0000));
  localparam logic signed [vkfs_pkg::H_W-1:0] ONE =
    vkfs_pkg::H_W'(1 << vkfs_pkg::FRAC_BITS);

  vkfs_pkg::back_state_e state_q, state_d;
  vkfs_pkg::mac_step_e   step_q, step_d;
  logic [1:0]                    comp_q, comp_d;
  logic [vkfs_pkg::KEY_AW-1:0]   j_q, j_d, nm1, rd_addr;
  logic [vkfs_pkg::DCNT_W-1:0]   cnt_q, cnt_d;
  logic                          out_valid_q, out_free, out_load, mem_we;

  // table memory
  vkfs_pkg::key_row_t mem [vkfs_pkg::MAX_KEYS];
  vkfs_pkg::key_row_t rd_row_q;
  vkfs_pkg::key_row_t row;

  // datapath registers
  vkfs_pkg::key_row_t lo_row_q, hi_row_q;
  logic [31:0]                         qtime_q, dt_q;
  logic [32:0]                         rem_q;
  logic [vkfs_pkg::U_W-1:0]            u_q, t2_q, t3_q;
  logic signed [vkfs_pkg::M_W-1:0]     m0_q, m1_q;
  logic signed [vkfs_pkg::PROD_W-1:0]  prod_q;
  logic signed [vkfs_pkg::ACC_W-1:0]   acc_q;
  logic [2:0][31:0]                    res_q, out_res_q;
  logic                                empty_q, out_empty_q;

  // datapath helpers
  logic                                div_ge;
  logic [32:0]                         div_r;
  logic [31:0]                         v0, v1, tout, tin;
  logic signed [vkfs_pkg::H_W-1:0]     t2s, t3s, us, h00, h01, h10, h11;
  logic signed [vkfs_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [vkfs_pkg::ACC_W-1:0]   sh, lin_sum, sat_in;
  logic [31:0]                         sat_val, fin_val;

  assign nm1      = vkfs_pkg::KEY_AW'(cfg_i.n_keys - vkfs_pkg::CNT_W'(1));
  assign row      = rd_row_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[vkfs_pkg::KEY_AW'(q_item_i.key_index)] <= q_item_i.row;
    end
    rd_row_q <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    comp_d  = comp_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    case (state_q)
      vkfs_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          case (q_item_i.cls)
            vkfs_pkg::CLS_EMPTY:  state_d = vkfs_pkg::BK_OUT;
            vkfs_pkg::CLS_SAMPLE: state_d = vkfs_pkg::BK_FIRST;
            default:              state_d = vkfs_pkg::BK_IDLE;
          endcase
        end
      end
      vkfs_pkg::BK_FIRST: begin
        state_d = (qtime_q <= row.key_time) ? vkfs_pkg::BK_OUT : vkfs_pkg::BK_LAST;
      end
      vkfs_pkg::BK_LAST: begin
        if (qtime_q >= row.key_time) begin
          state_d = vkfs_pkg::BK_OUT;
        end else begin
          state_d = vkfs_pkg::BK_SRCH;
          j_d     = vkfs_pkg::KEY_AW'(1);
        end
      end
      vkfs_pkg::BK_SRCH: begin
        if (qtime_q > row.key_time) begin
          j_d = j_q + vkfs_pkg::KEY_AW'(1);
        end else begin
          state_d = vkfs_pkg::BK_DIV;
          cnt_d   = '0;
        end
      end
      vkfs_pkg::BK_DIV: begin
        cnt_d = cnt_q + vkfs_pkg::DCNT_W'(1);
        if (cnt_q == vkfs_pkg::DCNT_W'(vkfs_pkg::DIV_STEPS - 1)) begin
          comp_d = 2'd0;
          case (cfg_i.mode)
            vkfs_pkg::MODE_HERMITE: begin
              step_d  = vkfs_pkg::ST_T2;
              state_d = vkfs_pkg::BK_MUL;
            end
            vkfs_pkg::MODE_LINEAR: begin
              step_d  = vkfs_pkg::ST_LIN;
              state_d = vkfs_pkg::BK_MUL;
            end
            default: state_d = vkfs_pkg::BK_FIN;
          endcase
        end
      end
      vkfs_pkg::BK_MUL: state_d = vkfs_pkg::BK_ACC;
      vkfs_pkg::BK_ACC: begin
        if (step_q == vkfs_pkg::ST_H11H || step_q == vkfs_pkg::ST_LIN) begin
          state_d = vkfs_pkg::BK_FIN;
        end else begin
          step_d  = vkfs_pkg::next_step(step_q);
          state_d = vkfs_pkg::BK_MUL;
        end
      end
      vkfs_pkg::BK_FIN: begin
        if (comp_q == 2'd2) begin
          state_d = vkfs_pkg::BK_OUT;
        end else begin
          comp_d = comp_q + 2'd1;
          case (cfg_i.mode)
            vkfs_pkg::MODE_HERMITE: begin
              step_d  = vkfs_pkg::ST_M0;
              state_d = vkfs_pkg::BK_MUL;
            end
            vkfs_pkg::MODE_LINEAR: begin
              step_d  = vkfs_pkg::ST_LIN;
              state_d = vkfs_pkg::BK_MUL;
            end
            default: state_d = vkfs_pkg::BK_FIN;
          endcase
        end
      end
      vkfs_pkg::BK_OUT: begin
        if (out_free) begin
          state_d = vkfs_pkg::BK_IDLE;
        end
      end
      default: state_d = vkfs_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    rd_addr  = '0;
    case (state_q)
      vkfs_pkg::BK_IDLE: begin
        q_pop_o = q_valid_i;
        mem_we  = q_valid_i && (q_item_i.cls == vkfs_pkg::CLS_WRITE) &&
                  (int'(q_item_i.key_index) < vkfs_pkg::MAX_KEYS);
      end
      vkfs_pkg::BK_FIRST: rd_addr = nm1;
      vkfs_pkg::BK_LAST:  rd_addr = vkfs_pkg::KEY_AW'(1);
      vkfs_pkg::BK_SRCH:  rd_addr = j_q + vkfs_pkg::KEY_AW'(1);
      vkfs_pkg::BK_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vkfs_pkg::BK_IDLE;
      step_q      <= vkfs_pkg::ST_T2;
      comp_q      <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      comp_q      <= comp_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // restoring divider step: one quotient bit per cycle
  always_comb begin
    div_ge = rem_q >= {1'b0, dt_q};
    div_r  = div_ge ? rem_q - {1'b0, dt_q} : rem_q;
  end

  // component operands and Hermite basis
  always_comb begin
    v0   = lo_row_q.val[comp_q];
    v1   = hi_row_q.val[comp_q];
    tout = lo_row_q.tan_out[comp_q];
    tin  = hi_row_q.tan_in[comp_q];
    t2s  = vkfs_pkg::H_W'(t2_q);
    t3s  = vkfs_pkg::H_W'(t3_q);
    us   = vkfs_pkg::H_W'(u_q);
    h00  = (t3s <<< 1) - (t2s + (t2s <<< 1)) + ONE;
    h10  = t3s - (t2s <<< 1) + us;
    h01  = (t2s + (t2s <<< 1)) - (t3s <<< 1);
    h11  = t3s - t2s;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      vkfs_pkg::ST_T2: begin
        mul_a = vkfs_pkg::MUL_W'(u_q);
        mul_b = vkfs_pkg::MUL_W'(u_q);
      end
      vkfs_pkg::ST_T3: begin
        mul_a = vkfs_pkg::MUL_W'(t2_q);
        mul_b = vkfs_pkg::MUL_W'(u_q);
      end
      vkfs_pkg::ST_M0: begin
        mul_a = vkfs_pkg::MUL_W'($signed(tout));
        mul_b = vkfs_pkg::MUL_W'({1'b0, dt_q});
      end
      vkfs_pkg::ST_M1: begin
        mul_a = vkfs_pkg::MUL_W'($signed(tin));
        mul_b = vkfs_pkg::MUL_W'({1'b0, dt_q});
      end
      vkfs_pkg::ST_H00: begin
        mul_a = vkfs_pkg::MUL_W'(h00);
        mul_b = vkfs_pkg::MUL_W'($signed(v0));
      end
      vkfs_pkg::ST_H01: begin
        mul_a = vkfs_pkg::MUL_W'(h01);
        mul_b = vkfs_pkg::MUL_W'($signed(v1));
      end
      vkfs_pkg::ST_H10L: begin
        mul_a = vkfs_pkg::MUL_W'(h10);
        mul_b = vkfs_pkg::MUL_W'(m0_q[vkfs_pkg::SPLIT-1:0]);
      end
      vkfs_pkg::ST_H10H: begin
        mul_a = vkfs_pkg::MUL_W'(h10);
        mul_b = vkfs_pkg::MUL_W'($signed(m0_q[vkfs_pkg::M_W-1:vkfs_pkg::SPLIT]));
      end
      vkfs_pkg::ST_H11L: begin
        mul_a = vkfs_pkg::MUL_W'(h11);
        mul_b = vkfs_pkg::MUL_W'(m1_q[vkfs_pkg::SPLIT-1:0]);
      end
      vkfs_pkg::ST_H11H: begin
        mul_a = vkfs_pkg::MUL_W'(h11);
        mul_b = vkfs_pkg::MUL_W'($signed(m1_q[vkfs_pkg::M_W-1:vkfs_pkg::SPLIT]));
      end
      vkfs_pkg::ST_LIN: begin
        mul_a = vkfs_pkg::MUL_W'($signed(v1)) - vkfs_pkg::MUL_W'($signed(v0));
        mul_b = vkfs_pkg::MUL_W'(u_q);
      end
      default: ;
    endcase
  end

  // final scaling, saturation and per-mode result
  always_comb begin
    sh      = acc_q >>> vkfs_pkg::FRAC_BITS;
    lin_sum = sh + vkfs_pkg::ACC_W'($signed(v0));
    sat_in  = (cfg_i.mode == vkfs_pkg::MODE_LINEAR) ? lin_sum : sh;
    if (sat_in > SAT_MAX) begin
      sat_val = 32'h7fff_ffff;
    end else if (sat_in < SAT_MIN) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = sat_in[31:0];
    end
    case (cfg_i.mode)
      vkfs_pkg::MODE_LINEAR,
      vkfs_pkg::MODE_HERMITE: fin_val = sat_val;
      vkfs_pkg::MODE_STEP:    fin_val = (qtime_q == hi_row_q.key_time) ? v1 : v0;
      default:                fin_val = '0;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      vkfs_pkg::BK_IDLE: begin
        qtime_q <= q_item_i.row.key_time;
        empty_q <= (q_item_i.cls == vkfs_pkg::CLS_EMPTY);
        res_q   <= '0;
      end
      vkfs_pkg::BK_FIRST: begin
        lo_row_q <= row;
        if (qtime_q <= row.key_time) begin
          res_q <= row.val;
        end
      end
      vkfs_pkg::BK_LAST: begin
        if (qtime_q >= row.key_time) begin
          res_q <= row.val;
        end
      end
      vkfs_pkg::BK_SRCH: begin
        if (qtime_q > row.key_time) begin
          lo_row_q <= row;
        end else begin
          hi_row_q <= row;
          dt_q     <= row.key_time - lo_row_q.key_time;
          rem_q    <= {1'b0, qtime_q - lo_row_q.key_time};
          u_q      <= '0;
        end
      end
      vkfs_pkg::BK_DIV: begin
        rem_q <= {div_r[31:0], 1'b0};
        u_q   <= {u_q[vkfs_pkg::U_W-2:0], div_ge};
      end
      vkfs_pkg::BK_MUL: begin
        prod_q <= vkfs_pkg::PROD_W'(mul_a) * vkfs_pkg::PROD_W'(mul_b);
      end
      vkfs_pkg::BK_ACC: begin
        case (step_q)
          vkfs_pkg::ST_T2:  t2_q <= prod_q[vkfs_pkg::FRAC_BITS +: vkfs_pkg::U_W];
          vkfs_pkg::ST_T3:  t3_q <= prod_q[vkfs_pkg::FRAC_BITS +: vkfs_pkg::U_W];
          vkfs_pkg::ST_M0:  m0_q <= prod_q[vkfs_pkg::FRAC_BITS +: vkfs_pkg::M_W];
          vkfs_pkg::ST_M1:  m1_q <= prod_q[vkfs_pkg::FRAC_BITS +: vkfs_pkg::M_W];
          vkfs_pkg::ST_H00,
          vkfs_pkg::ST_LIN: acc_q <= vkfs_pkg::ACC_W'(prod_q);
          vkfs_pkg::ST_H01,
          vkfs_pkg::ST_H10L,
          vkfs_pkg::ST_H11L: acc_q <= acc_q + vkfs_pkg::ACC_W'(prod_q);
          vkfs_pkg::ST_H10H,
          vkfs_pkg::ST_H11H: acc_q <= acc_q + (vkfs_pkg::ACC_W'(prod_q) <<< vkfs_pkg::SPLIT);
          default: ;
        endcase
      end
      vkfs_pkg::BK_FIN: res_q[comp_q] <= fin_val;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q   <= res_q;
      out_empty_q <= empty_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_x_o    = $signed(out_res_q[0]);
  assign result_y_o    = $signed(out_res_q[1]);
  assign result_z_o    = $signed(out_res_q[2]);
  assign table_empty_o = out_empty_q;

  `VKFS_ASSERT(a_out_from_seq, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == vkfs_pkg::BK_OUT), "result shown without sequencer load")
  `VKFS_ASSERT(a_srch_bound, clk_i, rst_ni, (state_q == vkfs_pkg::BK_SRCH) |-> (j_q <= nm1), "key search ran past last key")
  `VKFS_ASSERT(a_write_silent, clk_i, rst_ni, (state_q == vkfs_pkg::BK_IDLE && q_valid_i && q_item_i.cls == vkfs_pkg::CLS_WRITE) |=> (state_q == vkfs_pkg::BK_IDLE), "write request left idle")

endmodule

// File: rtl/vec3_keyframe_sampler.sv
// Top level of the 3-vector keyframe sampler.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   operation, key_index, time, values, tangents
//  out      output     out_valid_o / out_stall_i result_x/y/z, table_empty
//  cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A write request is stored from idle; an empty-table sample goes straight
// to the output. Other samples check the first and last keys, search up to
// key_count-1 keys, run the divider, and per component do eight multiplies
// in Hermite mode (plus two once), one in linear mode, none in step mode;
// the worst case is set by the single shared multiplier and the search.
// A two-entry queue decouples request intake from the sequencer; the result
// sits in an output register so the next request is taken while it waits.
// Reset clears control only; the key table holds garbage until written.
module vec3_keyframe_sampler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vkfs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [vkfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic [5:0]                       key_index_i,
  input  logic [31:0]                      time_value_i,
  input  logic signed [31:0]               value_x_i,
  input  logic signed [31:0]               value_y_i,
  input  logic signed [31:0]               value_z_i,
  input  logic signed [31:0]               tan_in_x_i,
  input  logic signed [31:0]               tan_in_y_i,
  input  logic signed [31:0]               tan_in_z_i,
  input  logic signed [31:0]               tan_out_x_i,
  input  logic signed [31:0]               tan_out_y_i,
  input  logic signed [31:0]               tan_out_z_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [31:0]               result_x_o,
  output logic signed [31:0]               result_y_o,
  output logic signed [31:0]               result_z_o,
  output logic                             table_empty_o
);

  vkfs_pkg::q_item_t push_item, pop_item;
  vkfs_pkg::cfg_t    cfg;
  logic              q_push, q_full, q_pop, q_valid;

  // request intake and configuration
  vkfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .key_index_i (key_index_i),
    .time_value_i(time_value_i),
    .value_x_i   (value_x_i),
    .value_y_i   (value_y_i),
    .value_z_i   (value_z_i),
    .tan_in_x_i  (tan_in_x_i),
    .tan_in_y_i  (tan_in_y_i),
    .tan_in_z_i  (tan_in_z_i),
    .tan_out_x_i (tan_out_x_i),
    .tan_out_y_i (tan_out_y_i),
    .tan_out_z_i (tan_out_z_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .q_push_o    (q_push),
    .q_item_o    (push_item),
    .cfg_o       (cfg)
  );

  // request queue
  vkfs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (pop_item)
  );

  // sequencer and datapath
  vkfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .q_item_i     (pop_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_x_o   (result_x_o),
    .result_y_o   (result_y_o),
    .result_z_o   (result_z_o),
    .table_empty_o(table_empty_o)
  );

endmodule
